FILE: sv/first_match_acl_decision_macros.svh
// ----------------------------------------------------------------------------
// first_match_acl_decision_macros
// Assertion shorthands shared by the decision block. They expect clk and
// arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef FIRST_MATCH_ACL_DECISION_MACROS_SVH
`define FIRST_MATCH_ACL_DECISION_MACROS_SVH

// Same-cycle implication, off during reset
`define FMACL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset
`define FMACL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/fmacl_pkg.sv
// ----------------------------------------------------------------------------
// fmacl_pkg
// Sizes, codes and shared types of the first-match access decision block.
// ----------------------------------------------------------------------------
`default_nettype none

package fmacl_pkg;

	localparam int ENTRY_SLOTS     = 16;
	localparam int RULES_PER_ENTRY = 8;

	localparam int SLOT_W     = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
	localparam int RIDX_W     = (RULES_PER_ENTRY > 1) ? $clog2(RULES_PER_ENTRY) : 1;
	localparam int CNT_W      = $clog2(RULES_PER_ENTRY + 1);
	localparam int RULE_DEPTH = ENTRY_SLOTS * RULES_PER_ENTRY;
	localparam int RULE_AW    = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;

	localparam int TAG_W = 16;
	localparam int ID_W  = 32;

	localparam logic [ID_W-1:0] WILDCARD_ID = '1;

	localparam logic [2:0] PERM_NONE = 3'b000;
	localparam logic [2:0] PERM_ALL  = 3'b111;
	localparam logic [2:0] PERM_READ = 3'b100;

	localparam logic [1:0] CONT_DENY   = 2'd0;
	localparam logic [1:0] CONT_PLAIN  = 2'd1;
	localparam logic [1:0] CONT_CIPHER = 2'd2;

	typedef enum logic [1:0] {
		REQ_SET    = 2'd0,
		REQ_WRITE  = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_CHECK  = 2'd3
	} req_t;

	// Item fields carried on s_tdata, last field in the lowest bits
	typedef struct packed {
		logic [2:0]      perm_mask;
		logic [1:0]      rule_content;
		logic [2:0]      rule_perm;
		logic            proc_specific;
		logic [ID_W-1:0] group_id;
		logic [ID_W-1:0] user_id;
		logic [3:0]      rule_count;
		logic [2:0]      rule_index;
		logic [TAG_W-1:0] acl_id;
		logic [3:0]      slot;
	} item_t;

	localparam int IN_FIELDS_W = $bits(item_t);
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

	// One stored rule
	typedef struct packed {
		logic [ID_W-1:0] uid;
		logic [ID_W-1:0] gid;
		logic            proc;
		logic [2:0]      perm;
		logic [1:0]      content;
	} rule_t;

	localparam int RULE_W = $bits(rule_t);

	// Result beat, perm in the lowest bits
	typedef struct packed {
		logic       status;
		logic [1:0] content;
		logic [2:0] perm;
	} result_t;

	localparam int RES_W       = $bits(result_t);
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic maint;
		logic bypass;
		logic tag_cmp;
		logic pick;
		logic scan;
		logic emit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_check;
		logic fast;
		logic go_scan;
		logic scan_end;
		logic table_en;
	} sts_t;

	function automatic logic [RULE_AW-1:0] rule_addr(input logic [SLOT_W-1:0] s,
			input logic [RIDX_W-1:0] r);
		rule_addr = RULE_AW'(s) * RULE_AW'(RULES_PER_ENTRY) + RULE_AW'(r);
	endfunction

endpackage

`default_nettype wire

FILE: sv/fmacl_ram.sv
// ----------------------------------------------------------------------------
// fmacl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module fmacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/fmacl_ctrl.sv
// ----------------------------------------------------------------------------
// fmacl_ctrl
// Sequencer: takes one item, steps the datapath through it, hands the
// result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fmacl_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output      logic          s_tready,
	output      logic          m_tvalid,
	input  wire logic          m_tready,
	input  wire fmacl_pkg::sts_t sts,
	output      fmacl_pkg::cmd_t cmd
);

	import fmacl_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PICK,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == ST_IDLE) && s_tvalid;
		cmd.maint   = (state_q == ST_EXEC) && !sts.is_check;
		cmd.bypass  = (state_q == ST_EXEC) && sts.is_check && sts.fast;
		cmd.tag_cmp = (state_q == ST_EXEC) && sts.is_check && !sts.fast;
		cmd.pick    = (state_q == ST_PICK);
		cmd.scan    = (state_q == ST_SCAN);
		cmd.emit    = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (cmd.emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (sts.is_check && !sts.fast) begin
						state_q <= ST_PICK;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_PICK: begin
					state_q <= sts.go_scan ? ST_SCAN : ST_DONE;
				end
				ST_SCAN: begin
					if (sts.scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/fmacl_dp.sv
// ----------------------------------------------------------------------------
// fmacl_dp
// Datapath: item register, entry table, rule memory, tag match, rule scan
// and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fmacl_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_wdata,
	input  wire logic [1:0]                        in_req,
	input  wire fmacl_pkg::item_t                  in_item,
	input  wire fmacl_pkg::cmd_t                   cmd,
	output      fmacl_pkg::sts_t                   sts,
	output      logic [fmacl_pkg::OUT_TDATA_W-1:0] out_data
);

	import fmacl_pkg::*;

	// Item and configuration
	logic  table_en_q;
	req_t  req_q;
	item_t item_q;

	// Entry table
	logic [ENTRY_SLOTS-1:0] entry_vld_q;
	logic [TAG_W-1:0]       entry_tag_q [ENTRY_SLOTS];
	logic [CNT_W-1:0]       entry_cnt_q [ENTRY_SLOTS];

	// Lookup and scan
	logic [ENTRY_SLOTS-1:0] hit_vec_s1;
	logic [SLOT_W-1:0]      sel_slot_q;
	logic [CNT_W-1:0]       sel_cnt_q;
	logic [CNT_W-1:0]       issue_q;
	logic                   rd_vld_s1;
	logic [RIDX_W-1:0]      rd_idx_s1;

	result_t res_q;
	result_t res_out_q;

	logic [SLOT_W-1:0] item_slot;
	logic              slot_ok;
	logic [SLOT_W-1:0] pick_idx;
	logic              pick_any;
	logic [SLOT_W-1:0] cnt_addr;
	logic [CNT_W-1:0]  cnt_rd;
	logic [CNT_W-1:0]  cnt_avail;
	logic [CNT_W-1:0]  cnt_sat;
	logic              refuse;
	logic              rule_we;
	logic              rd_en;
	logic [RULE_AW-1:0] rd_addr;
	rule_t             rule_wdata;
	rule_t             rule_rdata;
	logic              rule_hit;
	logic              rule_last;
	result_t           hit_res;

	assign item_slot = item_q.slot[SLOT_W-1:0];
	assign slot_ok   = (32'(item_q.slot) < ENTRY_SLOTS);

	// Lowest hit slot wins
	always_comb begin
		pick_idx = '0;
		for (int s = ENTRY_SLOTS - 1; s >= 0; s--) begin
			if (hit_vec_s1[s]) begin
				pick_idx = SLOT_W'(s);
			end
		end
	end
	assign pick_any = |hit_vec_s1;

	// Single read port on the count array, shared by pick and write check
	assign cnt_addr  = cmd.pick ? pick_idx : item_slot;
	assign cnt_rd    = entry_cnt_q[cnt_addr];
	assign cnt_avail = entry_vld_q[item_slot] ? cnt_rd : '0;
	assign cnt_sat   = (32'(item_q.rule_count) > RULES_PER_ENTRY) ?
		CNT_W'(RULES_PER_ENTRY) : CNT_W'(item_q.rule_count);

	assign refuse = (CNT_W'(item_q.rule_index) >= cnt_avail) ||
		(32'(item_q.rule_index) >= RULES_PER_ENTRY);

	assign rule_we = cmd.maint && (req_q == REQ_WRITE) && slot_ok && !refuse;

	assign rule_wdata.uid     = item_q.user_id;
	assign rule_wdata.gid     = item_q.group_id;
	assign rule_wdata.proc    = item_q.proc_specific;
	assign rule_wdata.perm    = item_q.rule_perm;
	assign rule_wdata.content = item_q.rule_content;

	// Rule read address: the write position while storing, the scan position otherwise
	assign rd_en   = cmd.scan && (issue_q < sel_cnt_q);
	assign rd_addr = rule_we ?
		rule_addr(item_slot, item_q.rule_index[RIDX_W-1:0]) :
		rule_addr(sel_slot_q, issue_q[RIDX_W-1:0]);

	fmacl_ram #(
		.WIDTH(RULE_W),
		.DEPTH(RULE_DEPTH)
	) u_rules (
		.clk  (clk),
		.we   (rule_we),
		.waddr(rd_addr),
		.wdata(rule_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rule_rdata)
	);

	// Evaluate the rule read in the previous cycle
	assign rule_hit = cmd.scan && rd_vld_s1 &&
		((rule_rdata.uid == WILDCARD_ID) || (rule_rdata.uid == item_q.user_id)) &&
		((rule_rdata.gid == WILDCARD_ID) || (rule_rdata.gid == item_q.group_id)) &&
		!rule_rdata.proc;
	assign rule_last = cmd.scan && rd_vld_s1 &&
		((CNT_W'(rd_idx_s1) + CNT_W'(1)) == sel_cnt_q);

	always_comb begin
		hit_res.status  = 1'b0;
		hit_res.content = rule_rdata.content;
		hit_res.perm    = rule_rdata.perm & item_q.perm_mask;
		case (rule_rdata.content)
			CONT_DENY, CONT_PLAIN: begin
			end
			CONT_CIPHER: begin
				hit_res.perm = hit_res.perm & PERM_READ;
			end
			default: begin
				hit_res.perm    = PERM_NONE;
				hit_res.content = CONT_DENY;
			end
		endcase
	end

	assign sts.is_check = (req_q == REQ_CHECK);
	assign sts.fast     = !table_en_q || (item_q.acl_id == '0);
	assign sts.go_scan  = pick_any && (cnt_rd != '0);
	assign sts.scan_end = rule_hit || rule_last;
	assign sts.table_en = table_en_q;

	assign out_data = OUT_TDATA_W'(res_out_q);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_en_q  <= 1'b0;
			entry_vld_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				table_en_q <= cfg_wdata;
			end
			if (cmd.maint && slot_ok) begin
				case (req_q)
					REQ_SET:    entry_vld_q[item_slot] <= 1'b1;
					REQ_REMOVE: entry_vld_q[item_slot] <= 1'b0;
					default: begin
					end
				endcase
			end
			if (cmd.pick) begin
				rd_vld_s1 <= 1'b0;
			end else if (cmd.scan) begin
				rd_vld_s1 <= rd_en;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_t'(in_req);
			item_q <= in_item;
		end
		if (cmd.maint && slot_ok) begin
			case (req_q)
				REQ_SET: begin
					entry_tag_q[item_slot] <= item_q.acl_id;
					entry_cnt_q[item_slot] <= cnt_sat;
				end
				REQ_REMOVE: begin
					entry_cnt_q[item_slot] <= '0;
				end
				default: begin
				end
			endcase
		end
		if (cmd.tag_cmp) begin
			for (int s = 0; s < ENTRY_SLOTS; s++) begin
				hit_vec_s1[s] <= entry_vld_q[s] && (entry_tag_q[s] == item_q.acl_id);
			end
		end
		if (cmd.pick) begin
			sel_slot_q <= pick_idx;
			sel_cnt_q  <= cnt_rd;
			issue_q    <= '0;
		end else if (rd_en) begin
			issue_q <= issue_q + CNT_W'(1);
		end
		if (rd_en) begin
			rd_idx_s1 <= issue_q[RIDX_W-1:0];
		end
		if (cmd.maint) begin
			res_q.perm    <= PERM_NONE;
			res_q.content <= CONT_DENY;
			res_q.status  <= (req_q == REQ_WRITE) && slot_ok && refuse;
		end else if (cmd.bypass) begin
			res_q.perm    <= table_en_q ? PERM_NONE : PERM_ALL;
			res_q.content <= table_en_q ? CONT_DENY : CONT_PLAIN;
			res_q.status  <= 1'b0;
		end else if (cmd.pick) begin
			res_q <= '0;
		end else if (rule_hit) begin
			res_q <= hit_res;
		end
		if (cmd.emit) begin
			res_out_q <= res_q;
		end
	end

endmodule

`default_nettype wire

FILE: sv/first_match_acl_decision.sv
// Sequence: a set, write or remove item, or a bypassed check, goes through execute and done;
//   a check that finds no tag or an empty rule list also passes the pick state, and one that
//   scans n rules (n at most RULES_PER_ENTRY) passes pick and then a scan state over them.
// Flow: one item in flight, the next taken the cycle after the result beat is loaded; a
//   result-side stall holds the item in the done state until the output register is free.
// Reset: arst_n clears the table enable, all entry valid bits and the handshake.
// ----------------------------------------------------------------------------
// first_match_acl_decision
// First-match access-control decision table with a stream-in, stream-out
// interface and a single configuration bit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_match_acl_decision_macros.svh"

module first_match_acl_decision (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Configuration: table_enabled
	input  wire logic                                 cfg_we,
	input  wire logic                                 cfg_wdata,
	// Request stream
	input  wire logic                                 s_tvalid,
	output      logic                                 s_tready,
	// s_tdata, from bit 0: slot[3:0], acl_id[15:0], rule_index[2:0],
	// rule_count[3:0], user_id[31:0], group_id[31:0], proc_specific,
	// rule_perm[2:0], rule_content[1:0], perm_mask[2:0], zero pad
	input  wire logic [fmacl_pkg::IN_TDATA_W-1:0]     s_tdata,
	// s_tuser: req_type[1:0]
	input  wire logic [1:0]                           s_tuser,
	// Result stream
	output      logic                                 m_tvalid,
	input  wire logic                                 m_tready,
	// m_tdata, from bit 0: perm_out[2:0], content_out[1:0], status, zero pad
	output      logic [fmacl_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	import fmacl_pkg::*;

	cmd_t  cmd;
	sts_t  sts;
	item_t in_item;

	// Drop the pad bits, keep the packed fields
	assign in_item = item_t'(s_tdata[IN_FIELDS_W-1:0]);

	// Sequencer: accept, execute, pick, scan, hand over the result beat
	fmacl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Storage, tag match, rule scan and result registers
	fmacl_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_req   (s_tuser),
		.in_item  (in_item),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (m_tdata)
	);

	// Only one item in flight: input closes right after a beat is taken
	`FMACL_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready,
		"second item accepted while one is in flight")

	// Never overwrite a result beat that is still waiting
	`FMACL_ASSERT_IMP(a_emit_free, cmd.emit, !m_tvalid || m_tready,
		"result register loaded while holding an untaken beat")

	// The rule scan runs only with the table enabled
	`FMACL_ASSERT_IMP(a_scan_enabled, cmd.scan, sts.table_en,
		"rule scan while the table is disabled")

	// Commands are mutually exclusive
	`FMACL_ASSERT_IMP(a_cmd_excl, 1'b1,
		$onehot0({cmd.load, cmd.maint, cmd.bypass, cmd.tag_cmp, cmd.pick, cmd.scan, cmd.emit}),
		"more than one datapath command at once")

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-match access decision table. A short
// directed table opens the run, then randomized phases follow. Each phase
// sets up entries, loads their rule lists and probes them with checks,
// mixed with free-form noise beats. Both stream sides idle at random. Every
// result beat is compared against a local model of the table or a fixed expected beat.
// ----------------------------------------------------------------------------

module tb;

	import fmacl_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int TAIL_CYCLES  = 3 * (5 + RULES_PER_ENTRY);
	localparam int PHASES       = 12;
	localparam int PHASE_BEATS  = 150;
	localparam int REPORT_LIMIT = 10;

	// Content code with no meaning; a matching rule holding it denies
	localparam logic [1:0] CONT_RESERVED = 2'd3;

	// Result beats that can be read off directly
	localparam result_t ACCEPTED  = {1'b0, CONT_DENY, PERM_NONE};
	localparam result_t DENIED    = {1'b0, CONT_DENY, PERM_NONE};
	localparam result_t REFUSED   = {1'b1, CONT_DENY, PERM_NONE};
	localparam result_t ALLOW_ALL = {1'b0, CONT_PLAIN, PERM_ALL};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic                   cfg_wdata = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [1:0]             s_tuser = REQ_SET;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	first_match_acl_decision dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Local copy of the table, updated as each request beat is taken
	// ------------------------------------------------------------------
	bit              table_on;
	bit              ent_valid [ENTRY_SLOTS];
	logic [TAG_W-1:0] ent_tag  [ENTRY_SLOTS];
	int              ent_count [ENTRY_SLOTS];
	rule_t           rule_mem  [RULE_DEPTH];
	// Rule positions written since reset; the block holds garbage elsewhere
	bit              rule_seen [RULE_DEPTH];

	result_t awaited_beats[$];
	int      bad_beats;
	int      cycle_count;
	// Set during a phase that runs with no idling on either side
	bit      calm;
	int      sink_hold;

	logic [TAG_W-1:0] tag_pool   [6];
	logic [ID_W-1:0]  ident_pool [4];

	typedef struct {
		req_t    req;
		item_t   it;
		bit      typed;
		result_t want;
	} plan_row_t;

	plan_row_t plan[$];

	function automatic item_t acl_item(int unsigned slot, int unsigned id,
			int unsigned ridx, int unsigned cnt, logic [ID_W-1:0] uid,
			logic [ID_W-1:0] gid, int unsigned proc, int unsigned perm,
			int unsigned cont, int unsigned mask);
		item_t it;
		it.slot          = 4'(slot);
		it.acl_id        = TAG_W'(id);
		it.rule_index    = 3'(ridx);
		it.rule_count    = 4'(cnt);
		it.user_id       = uid;
		it.group_id      = gid;
		it.proc_specific = 1'(proc);
		it.rule_perm     = 3'(perm);
		it.rule_content  = 2'(cont);
		it.perm_mask     = 3'(mask);
		return it;
	endfunction

	// Walk the rule list of the first slot carrying the tag, in priority
	// order. Return 1 when the walk reaches a rule position that was never
	// written, since the block's answer there is undefined.
	function automatic bit walk_rules(item_t it, output result_t res);
		int    hit;
		int    pos;
		rule_t ru;
		res = DENIED;
		hit = -1;
		if (it.acl_id == '0)
			return 1'b0;
		for (int s = ENTRY_SLOTS - 1; s >= 0; s--)
			if (ent_valid[s] && ent_tag[s] == it.acl_id)
				hit = s;
		if (hit < 0)
			return 1'b0;
		for (int r = 0; r < ent_count[hit]; r++) begin
			pos = hit * RULES_PER_ENTRY + r;
			if (!rule_seen[pos])
				return 1'b1;
			ru = rule_mem[pos];
			if ((ru.uid == WILDCARD_ID || ru.uid == it.user_id) &&
					(ru.gid == WILDCARD_ID || ru.gid == it.group_id) && !ru.proc) begin
				// First subject match decides; an unknown content code denies
				if (ru.content != CONT_RESERVED) begin
					res.perm    = ru.perm & it.perm_mask;
					res.content = ru.content;
					if (ru.content == CONT_CIPHER)
						res.perm = res.perm & PERM_READ;
				end
				return 1'b0;
			end
		end
		return 1'b0;
	endfunction

	// Apply one request to the local table and return its result beat
	function automatic result_t apply_request(req_t r, item_t it);
		result_t res;
		int      pos;
		res = ACCEPTED;
		case (r)
			REQ_CHECK: begin
				if (!table_on)
					res = ALLOW_ALL;
				else
					void'(walk_rules(it, res));
			end
			REQ_SET: begin
				ent_valid[it.slot] = 1'b1;
				ent_tag[it.slot]   = it.acl_id;
				ent_count[it.slot] = (it.rule_count > RULES_PER_ENTRY) ?
					RULES_PER_ENTRY : int'(it.rule_count);
			end
			REQ_REMOVE: begin
				// Drop the entry, keep its rule contents
				ent_valid[it.slot] = 1'b0;
				ent_count[it.slot] = 0;
			end
			default: begin
				if (!ent_valid[it.slot] || it.rule_index >= ent_count[it.slot]) begin
					res.status = 1'b1;
				end else begin
					pos = int'(it.slot) * RULES_PER_ENTRY + int'(it.rule_index);
					rule_mem[pos].uid     = it.user_id;
					rule_mem[pos].gid     = it.group_id;
					rule_mem[pos].proc    = it.proc_specific;
					rule_mem[pos].perm    = it.rule_perm;
					rule_mem[pos].content = it.rule_content;
					rule_seen[pos]        = 1'b1;
				end
			end
		endcase
		return res;
	endfunction

	// Mostly short stalls, now and then a long one
	function automatic int stall_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [ID_W-1:0] pick_ident();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return ident_pool[$urandom_range(0, 3)];
			6, 7:             return WILDCARD_ID;
			8:                return '0;
			default:          return $urandom;
		endcase
	endfunction

	function automatic logic [TAG_W-1:0] pick_tag();
		if ($urandom_range(0, 9) < 8)
			return tag_pool[$urandom_range(0, 5)];
		return TAG_W'($urandom_range(0, 16'hFFFF));
	endfunction

	task automatic plan_beat(req_t r, item_t it, bit typed, result_t want);
		plan_row_t row;
		row.req   = r;
		row.it    = it;
		row.typed = typed;
		row.want  = want;
		plan.push_back(row);
	endtask

	// Drive one request beat, hold it until taken, then record what the
	// block must answer. Leave tvalid high so a following beat can go out
	// back to back.
	task automatic send_item(req_t r, item_t it, bit typed, result_t want);
		int      gap;
		result_t model_res;
		// Steer a check away from rule positions the block never stored
		if (r == REQ_CHECK && table_on && walk_rules(it, model_res))
			it.acl_id = '0;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 45)
			gap = stall_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r;
		s_tdata  <= IN_TDATA_W'(it);
		do @(posedge clk); while (!s_tready);
		model_res = apply_request(r, it);
		awaited_beats.push_back(typed ? want : model_res);
	endtask

	// Write the enable register only with nothing in flight
	task automatic set_table_enable(bit v);
		s_tvalid <= 1'b0;
		while (awaited_beats.size() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		table_on = v;
	endtask

	// One randomized phase. Most of it is well-formed: set an entry, load
	// every rule it uses, then probe it. The rest is free-form noise.
	task automatic run_phase(int budget);
		int               sent;
		int               used;
		logic [3:0]       slot;
		logic [3:0]       cnt;
		logic [TAG_W-1:0] tag;
		logic [1:0]       cont;
		req_t             r;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 9) < 7) begin
				slot = 4'($urandom_range(0, ENTRY_SLOTS - 1));
				tag  = pick_tag();
				cnt  = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) :
					$urandom_range(0, RULES_PER_ENTRY));
				used = (cnt > RULES_PER_ENTRY) ? RULES_PER_ENTRY : int'(cnt);
				send_item(REQ_SET, acl_item(slot, tag, $urandom_range(0, 7), cnt,
					$urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 7),
					$urandom_range(0, 3), $urandom_range(0, 7)), 1'b0, ACCEPTED);
				sent++;
				for (int k = 0; k < used; k++) begin
					case ($urandom_range(0, 9))
						0, 1:       cont = CONT_DENY;
						2, 3, 4, 5: cont = CONT_PLAIN;
						6, 7, 8:    cont = CONT_CIPHER;
						default:    cont = CONT_RESERVED;
					endcase
					send_item(REQ_WRITE, acl_item(slot, $urandom_range(0, 16'hFFFF), k,
						$urandom_range(0, 15), pick_ident(), pick_ident(),
						$urandom_range(0, 4) == 0, $urandom_range(0, 7), cont,
						$urandom_range(0, 7)), 1'b0, ACCEPTED);
					sent++;
				end
				// Now and then try a position past the count
				if (used < RULES_PER_ENTRY && $urandom_range(0, 7) == 0) begin
					send_item(REQ_WRITE, acl_item(slot, tag, $urandom_range(used, 7), 0,
						pick_ident(), pick_ident(), 0, $urandom_range(0, 7),
						CONT_PLAIN, 3'b111), 1'b0, ACCEPTED);
					sent++;
				end
				repeat ($urandom_range(1, 6)) begin
					send_item(REQ_CHECK, acl_item($urandom_range(0, 15),
						($urandom_range(0, 3) != 0) ? tag : pick_tag(),
						$urandom_range(0, 7), $urandom_range(0, 15), pick_ident(),
						pick_ident(), $urandom_range(0, 1), $urandom_range(0, 7),
						$urandom_range(0, 3), $urandom_range(0, 7)), 1'b0, ACCEPTED);
					sent++;
				end
				if ($urandom_range(0, 4) == 0) begin
					send_item(REQ_REMOVE, acl_item(slot, $urandom_range(0, 16'hFFFF),
						$urandom_range(0, 7), $urandom_range(0, 15), $urandom, $urandom,
						$urandom_range(0, 1), $urandom_range(0, 7), $urandom_range(0, 3),
						$urandom_range(0, 7)), 1'b0, ACCEPTED);
					sent++;
				end
			end else begin
				r = req_t'($urandom_range(0, 3));
				send_item(r, acl_item($urandom_range(0, 15),
					($urandom_range(0, 1) != 0) ? pick_tag() : $urandom_range(0, 16'hFFFF),
					$urandom_range(0, 7), $urandom_range(0, 15), $urandom, $urandom,
					$urandom_range(0, 1), $urandom_range(0, 7), $urandom_range(0, 3),
					$urandom_range(0, 7)), 1'b0, ACCEPTED);
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random back-pressure, then compare every beat taken
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (sink_hold > 0)
			sink_hold--;
		else if (!calm && $urandom_range(0, 99) < 30)
			sink_hold = stall_len();
		m_tready <= (sink_hold == 0);
	end

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[RES_W-1:0]);
			if (awaited_beats.size() == 0) begin
				if (bad_beats < REPORT_LIMIT)
					$display("result beat with no request outstanding: perm %0d content %0d status %0d",
						got.perm, got.content, got.status);
				bad_beats++;
			end else begin
				want = awaited_beats.pop_front();
				if (got.perm !== want.perm || got.content !== want.content ||
						got.status !== want.status) begin
					if (bad_beats < REPORT_LIMIT)
						$display("mismatch: expected perm %0d content %0d status %0d, got perm %0d content %0d status %0d",
							want.perm, want.content, want.status,
							got.perm, got.content, got.status);
					bad_beats++;
				end
			end
		end
	end

	// Hard stop on a hang
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		int on_at;
		tag_pool[0] = 16'hFFFF;
		tag_pool[1] = 16'h0001;
		for (int k = 2; k < 6; k++)
			tag_pool[k] = TAG_W'($urandom_range(2, 16'hFFFE));
		ident_pool[0] = '0;
		ident_pool[1] = 32'hFFFF_FFFE;
		ident_pool[2] = $urandom;
		ident_pool[3] = $urandom;

		// Directed table. The enable register still holds its reset value
		// for the first rows, so checks there answer allow-all.
		plan_beat(REQ_CHECK, acl_item(0, 16'h1234, 0, 0, 0, 0, 0, 0, 0, 3'b000),
			1'b1, ALLOW_ALL);
		plan_beat(REQ_SET, acl_item(0, 16'h00AA, 0, 3, 0, 0, 0, 0, 0, 0),
			1'b1, ACCEPTED);
		plan_beat(REQ_WRITE, acl_item(0, 0, 0, 0, 100, 200, 0, 3'b111, CONT_PLAIN, 0),
			1'b1, ACCEPTED);
		// Process-specific rule: stored, but never matches
		plan_beat(REQ_WRITE, acl_item(0, 0, 1, 0, WILDCARD_ID, 200, 1, 3'b111,
			CONT_PLAIN, 0), 1'b1, ACCEPTED);
		plan_beat(REQ_WRITE, acl_item(0, 0, 2, 0, WILDCARD_ID, WILDCARD_ID, 0, 3'b111,
			CONT_CIPHER, 0), 1'b1, ACCEPTED);
		// Index at the entry count: refused
		plan_beat(REQ_WRITE, acl_item(0, 0, 3, 0, 1, 1, 0, 3'b111, CONT_PLAIN, 0),
			1'b1, REFUSED);
		// Slot never set: its count reads as zero
		plan_beat(REQ_WRITE, acl_item(5, 0, 0, 0, 1, 1, 0, 3'b111, CONT_PLAIN, 0),
			1'b1, REFUSED);
		// Oversized count saturates, so the top position is writable
		plan_beat(REQ_SET, acl_item(15, 16'hFFFF, 7, 15, 0, 0, 0, 0, 0, 0),
			1'b1, ACCEPTED);
		plan_beat(REQ_WRITE, acl_item(15, 0, 7, 0, 0, 0, 0, 3'b101, CONT_DENY, 0),
			1'b1, ACCEPTED);

		on_at = plan.size();
		plan_beat(REQ_CHECK, acl_item(0, 16'h0000, 0, 0, 100, 200, 0, 0, 0, 3'b111),
			1'b1, DENIED);
		plan_beat(REQ_CHECK, acl_item(0, 16'h00AA, 0, 0, 100, 200, 0, 0, 0, 3'b111),
			1'b0, ACCEPTED);
		// Falls past the process rule onto the ciphertext wildcard
		plan_beat(REQ_CHECK, acl_item(0, 16'h00AA, 0, 0, 5, 200, 0, 0, 0, 3'b111),
			1'b0, ACCEPTED);
		plan_beat(REQ_CHECK, acl_item(0, 16'h00BB, 0, 0, 100, 200, 0, 0, 0, 3'b111),
			1'b1, DENIED);
		// Matching rule with the reserved content code denies
		plan_beat(REQ_SET, acl_item(1, 16'h00CC, 0, 1, 0, 0, 0, 0, 0, 0),
			1'b1, ACCEPTED);
		plan_beat(REQ_WRITE, acl_item(1, 0, 0, 0, 7, 7, 0, 3'b111, CONT_RESERVED, 0),
			1'b1, ACCEPTED);
		plan_beat(REQ_CHECK, acl_item(0, 16'h00CC, 0, 0, 7, 7, 0, 0, 0, 3'b111),
			1'b1, DENIED);
		plan_beat(REQ_CHECK, acl_item(0, 16'h00CC, 0, 0, 8, 7, 0, 0, 0, 3'b111),
			1'b1, DENIED);
		// Duplicate tag in a higher slot: the lower slot wins until removed
		plan_beat(REQ_SET, acl_item(2, 16'h00AA, 0, 1, 0, 0, 0, 0, 0, 0),
			1'b1, ACCEPTED);
		plan_beat(REQ_WRITE, acl_item(2, 0, 0, 0, WILDCARD_ID, WILDCARD_ID, 0, 3'b001,
			CONT_PLAIN, 0), 1'b1, ACCEPTED);
		plan_beat(REQ_CHECK, acl_item(0, 16'h00AA, 0, 0, 100, 200, 0, 0, 0, 3'b111),
			1'b0, ACCEPTED);
		plan_beat(REQ_REMOVE, acl_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, ACCEPTED);
		plan_beat(REQ_CHECK, acl_item(0, 16'h00AA, 0, 0, WILDCARD_ID, WILDCARD_ID, 0,
			0, 0, 3'b111), 1'b0, ACCEPTED);
		// Deny content still reports the masked perm bits
		plan_beat(REQ_SET, acl_item(3, 16'h00DD, 0, 1, 0, 0, 0, 0, 0, 0),
			1'b1, ACCEPTED);
		plan_beat(REQ_WRITE, acl_item(3, 0, 0, 0, WILDCARD_ID, 32'hFFFF_FFFE, 0,
			3'b110, CONT_DENY, 0), 1'b1, ACCEPTED);
		plan_beat(REQ_CHECK, acl_item(0, 16'h00DD, 0, 0, 0, 32'hFFFF_FFFE, 0, 0, 0,
			3'b111), 1'b0, ACCEPTED);
		// Entry with no rules in use
		plan_beat(REQ_SET, acl_item(4, 16'h00EE, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b1, ACCEPTED);
		plan_beat(REQ_CHECK, acl_item(0, 16'h00EE, 0, 0, 0, 0, 0, 0, 0, 3'b111),
			1'b1, DENIED);
		// Removed slot refuses rule writes
		plan_beat(REQ_REMOVE, acl_item(15, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, ACCEPTED);
		plan_beat(REQ_WRITE, acl_item(15, 0, 0, 0, 0, 0, 0, 3'b111, CONT_PLAIN, 0),
			1'b1, REFUSED);

		// Hold reset, then release
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (i == on_at)
				set_table_enable(1'b1);
			send_item(plan[i].req, plan[i].it, plan[i].typed, plan[i].want);
		end

		// Random phases, each behind a fresh enable setting; every fourth
		// phase runs with both sides streaming flat out
		for (int p = 0; p < PHASES; p++) begin
			if (p == 1)
				set_table_enable(1'b0);
			else if (p == 0)
				set_table_enable(1'b1);
			else
				set_table_enable($urandom_range(0, 3) != 0);
			calm = (p % 4 == 3);
			run_phase(PHASE_BEATS);
		end
		calm = 1'b0;

		// Drain, then give the block time to show any stray beat
		s_tvalid <= 1'b0;
		while (awaited_beats.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (bad_beats == 0 && awaited_beats.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
